>>> hdl/fcf_pkg.sv
// Shared types and constants for the FIR filter with coefficient crossfade.
// Used by the datapath, the controller, the top level and the checker.
// No dependencies.
package fcf_pkg;

  // Filter dimensions.
  localparam int unsigned MAX_TAPS    = 64;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COEF_BITS   = 18;

  // Derived widths.
  localparam int unsigned TAP_W   = $clog2(MAX_TAPS);
  localparam int unsigned CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int unsigned FADE_W  = 16;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned NUM_W   = FADE_W + WGT_W + 1;
  localparam int unsigned MIX_W   = COEF_BITS + WGT_W + 2;
  localparam int unsigned PROD_W  = COEF_BITS + SAMPLE_BITS;
  localparam int unsigned ACC_W   = PROD_W + TAP_W;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Crossfade weight of one in Q1.16, and half an LSB of the blend.
  localparam logic [WGT_W-1:0] W_ONE  = WGT_W'(65536);
  localparam int unsigned      W_HALF = 32768;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEPS = 1'b1;

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_COMMIT = 2'd2
  } kind_e;

  // What a tap read in the datapath pipeline is for.
  typedef enum logic [1:0] {
    OP_MAC  = 2'd0,
    OP_CMP  = 2'd1,
    OP_COPY = 2'd2
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             clr;
    logic             hist_wr;
    logic             rd;
    op_e              op;
    logic [TAP_W-1:0] k;
    logic             acc_clr;
    logic             cmp_clr;
    logic             div_start;
    logic             fade_step;
    logic             commit;
    logic             out_load;
  } fcf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             fading;
    logic             last;
    logic             div_done;
    logic             diff;
    logic             out_free;
    logic [CNT_W-1:0] tap_count;
  } fcf_sts_t;

endpackage

>>> hdl/fcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/fcf_div.sv
// Bit-serial restoring divider for the crossfade weight, one quotient bit a cycle.
// Depends on fcf_pkg.
module fcf_div
  import fcf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [WGT_W-1:0] den_i,
  output logic             done_o,
  output logic [WGT_W-1:0] quot_o
);

  localparam int unsigned IT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [IT_W-1:0]  cnt_q;
  logic [WGT_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [WGT_W-1:0] den_q;
  logic [WGT_W:0]   trial;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == IT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? WGT_W'(trial - {1'b0, den_q}) : trial[WGT_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[WGT_W-1:0];

endmodule

>>> hdl/fcf_dp.sv
// Datapath: coefficient and history memories, blend and multiply-accumulate
// pipeline, crossfade state, weight divider and output register.
// Depends on fcf_pkg, fcf_ram and fcf_div.
module fcf_dp
  import fcf_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcf_cmd_t                      cmd_i,
  output fcf_sts_t                      sts_o,
  input  logic                          in_acc_i,
  input  logic [1:0]                    kind_i,
  input  logic [TAP_W-1:0]              tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [COEF_BITS-1:0]   coefficient_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned CB = COEF_BITS;
  localparam int unsigned PW = TAP_W + 1;

  // Configuration and crossfade state.
  logic [CNT_W-1:0]  tc_q;
  logic [FADE_W-1:0] fs_q;
  logic [FADE_W-1:0] idx_q;
  logic              fading_q;
  logic [WGT_W-1:0]  wcur_q;
  logic [TAP_W-1:0]  wp_q;
  logic [MAX_TAPS-1:0] hist_vld_q;
  logic signed [SB-1:0] sample_q;
  logic              diff_q;
  logic signed [ACC_W-1:0] acc_q;
  logic              out_valid_q;
  logic signed [SB-1:0] filt_q;

  // Pipeline registers.
  logic              p1_vld_q, p2_vld_q, p3_vld_q;
  op_e               p1_op_q, p2_op_q;
  logic [TAP_W-1:0]  p1_k_q, p2_k_q;
  logic              p1_hv_q;
  logic signed [MIX_W-1:0] mix_q;
  logic [CB-1:0]     prev2_q, pend2_q;
  logic signed [SB-1:0] hist2_q;
  logic signed [PROD_W-1:0] prod_q;

  // Memory ports.
  logic [SB-1:0]     hist_rd;
  logic [CB-1:0]     pend_rd, tgt_rd, prev_rd;
  logic              pend_we, tgt_we, prev_we;
  logic [TAP_W-1:0]  pend_wa, tgt_wa, prev_wa;
  logic [CB-1:0]     pend_wd, tgt_wd, prev_wd;
  logic [PW-1:0]     pos_sum, pos_w;
  logic [TAP_W-1:0]  hist_ra;

  // Arithmetic.
  logic              last;
  logic [WGT_W-1:0]  idx_p1, den;
  logic [NUM_W-1:0]  num;
  logic              div_done;
  logic [WGT_W-1:0]  quot;
  logic signed [CB:0] diff_s;
  logic signed [WGT_W:0] w_s;
  logic signed [MIX_W-1:0] mix_d, bsum;
  logic signed [CB-1:0] live;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0] rnd, shr;
  logic signed [SB-1:0] sat;
  logic              load_ok;
  logic [CNT_W-1:0]  tc_new;

  // Weight for the next blend step.
  assign last   = idx_q >= fs_q;
  assign idx_p1 = {1'b0, idx_q} + 1'b1;
  assign den    = {1'b0, fs_q} + 1'b1;
  assign num    = (NUM_W'(idx_p1) << 16) + NUM_W'(den >> 1);

  fcf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Circular history position for tap k.
  assign pos_sum = {1'b0, wp_q} + {1'b0, cmd_i.k};
  assign pos_w   = (pos_sum >= PW'(tc_q)) ? pos_sum - PW'(tc_q) : pos_sum;
  assign hist_ra = pos_w[TAP_W-1:0];

  fcf_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hist_wr),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .raddr_i (hist_ra),
    .rdata_o (hist_rd)
  );

  // Pending bank: loads, or zeros during the clearing pass.
  assign load_ok = in_acc_i && (kind_i == KIND_LOAD) && ({1'b0, tap_index_i} < PW'(MAX_TAPS));
  assign pend_we = cmd_i.clr || load_ok;
  assign pend_wa = cmd_i.clr ? cmd_i.k : tap_index_i;
  assign pend_wd = cmd_i.clr ? '0 : coefficient_i;

  fcf_ram #(.WIDTH(CB), .DEPTH(MAX_TAPS)) u_pend (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_wa),
    .wdata_i (pend_wd),
    .raddr_i (cmd_i.k),
    .rdata_o (pend_rd)
  );

  // Target bank: committed copy; previous bank: the live tap; zeros during clearing.
  assign tgt_we  = cmd_i.clr || (p2_vld_q && p2_op_q == OP_COPY);
  assign tgt_wa  = cmd_i.clr ? cmd_i.k : p2_k_q;
  assign tgt_wd  = cmd_i.clr ? '0 : pend2_q;
  assign prev_we = tgt_we;
  assign prev_wa = tgt_wa;
  assign prev_wd = cmd_i.clr ? '0 : live;

  fcf_ram #(.WIDTH(CB), .DEPTH(MAX_TAPS)) u_tgt (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (tgt_wa),
    .wdata_i (tgt_wd),
    .raddr_i (cmd_i.k),
    .rdata_o (tgt_rd)
  );

  fcf_ram #(.WIDTH(CB), .DEPTH(MAX_TAPS)) u_prev (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_wa),
    .wdata_i (prev_wd),
    .raddr_i (cmd_i.k),
    .rdata_o (prev_rd)
  );

  // Stage 1: weighted difference of target and previous tap.
  assign diff_s = $signed({tgt_rd[CB-1], tgt_rd}) - $signed({prev_rd[CB-1], prev_rd});
  assign w_s    = $signed({1'b0, wcur_q});
  assign mix_d  = diff_s * w_s;

  // Stage 2: live tap = floor((prev * 2^16 + diff * w + half) / 2^16).
  assign bsum = $signed({{(MIX_W - CB - 16){prev2_q[CB-1]}}, prev2_q, 16'b0})
              + mix_q + $signed(MIX_W'(W_HALF));
  assign live   = bsum[CB+15:16];
  assign prod_d = live * hist2_q;

  // Output rounding and saturation.
  assign rnd = acc_q + $signed(ACC_W'(1) <<< (CB - 2));
  assign shr = rnd >>> (CB - 1);
  always_comb begin
    if (shr > $signed(ACC_W'((1 << (SB - 1)) - 1))) begin
      sat = {1'b0, {(SB - 1){1'b1}}};
    end else if (shr < -$signed(ACC_W'(1 << (SB - 1)))) begin
      sat = {1'b1, {(SB - 1){1'b0}}};
    end else begin
      sat = shr[SB-1:0];
    end
  end

  // Tap count clamped to one through the maximum.
  always_comb begin
    tc_new = cfg_data_i[CNT_W-1:0];
    if (tc_new == '0) begin
      tc_new = CNT_W'(1);
    end else if (tc_new > CNT_W'(MAX_TAPS)) begin
      tc_new = CNT_W'(MAX_TAPS);
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q        <= CNT_W'(1);
      fs_q        <= '0;
      idx_q       <= '0;
      fading_q    <= 1'b0;
      wcur_q      <= W_ONE;
      wp_q        <= '0;
      hist_vld_q  <= '0;
      diff_q      <= 1'b0;
      out_valid_q <= 1'b0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      p3_vld_q    <= 1'b0;
    end else begin
      p1_vld_q <= cmd_i.rd;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q && (p2_op_q == OP_MAC);

      if (cfg_we_i && cfg_index_i == CFG_TAP_COUNT) begin
        tc_q       <= tc_new;
        wp_q       <= TAP_W'(tc_new - 1'b1);
        hist_vld_q <= '0;
        fading_q   <= 1'b0;
        idx_q      <= '0;
        wcur_q     <= W_ONE;
      end else begin
        if (cfg_we_i && cfg_index_i == CFG_FADE_STEPS) begin
          fs_q <= cfg_data_i[FADE_W-1:0];
        end
        if (cmd_i.fade_step) begin
          if (last) begin
            wcur_q   <= W_ONE;
            fading_q <= 1'b0;
          end else begin
            wcur_q <= quot;
            idx_q  <= idx_q + 1'b1;
          end
        end
        if (cmd_i.commit) begin
          wcur_q   <= '0;
          fading_q <= 1'b1;
          idx_q    <= '0;
        end
        if (cmd_i.hist_wr) begin
          hist_vld_q[wp_q] <= 1'b1;
        end
        if (cmd_i.out_load) begin
          wp_q <= (wp_q == '0) ? TAP_W'(tc_q - 1'b1) : wp_q - 1'b1;
        end
      end

      if (cmd_i.cmp_clr) begin
        diff_q <= 1'b0;
      end else if (p1_vld_q && p1_op_q == OP_CMP && pend_rd != tgt_rd) begin
        diff_q <= 1'b1;
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers of the pipeline, accumulator and output.
  always_ff @(posedge clk_i) begin
    if (in_acc_i && kind_i == KIND_SAMPLE) begin
      sample_q <= sample_i;
    end
    p1_op_q <= cmd_i.op;
    p1_k_q  <= cmd_i.k;
    p1_hv_q <= hist_vld_q[hist_ra];
    p2_op_q <= p1_op_q;
    p2_k_q  <= p1_k_q;
    mix_q   <= mix_d;
    prev2_q <= prev_rd;
    pend2_q <= pend_rd;
    hist2_q <= p1_hv_q ? $signed(hist_rd) : '0;
    prod_q  <= prod_d;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (p3_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.out_load) begin
      filt_q <= sat;
    end
  end

  assign sts_o.fading    = fading_q;
  assign sts_o.last      = last;
  assign sts_o.div_done  = div_done;
  assign sts_o.diff      = diff_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.tap_count = tc_q;

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filt_q;

endmodule

>>> hdl/fcf_ctrl.sv
// Controller: sequences the clearing pass, sample filtering, commit compare
// and commit copy over the taps. Depends on fcf_pkg.
module fcf_ctrl
  import fcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_acc_i,
  input  logic [1:0] kind_i,
  input  fcf_sts_t   sts_i,
  output fcf_cmd_t   cmd_o,
  output logic       in_ready_o
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_FADE, ST_DIV, ST_HWR, ST_MAC, ST_MDRAIN,
    ST_OUT, ST_CMP, ST_CDRAIN, ST_COPY, ST_PDRAIN
  } state_e;

  state_e           state_q;
  logic [TAP_W-1:0] k_q;
  logic [1:0]       cnt_q;
  logic             k_end_tc;
  logic             k_end_max;

  assign k_end_tc  = {1'b0, k_q} == (TAP_W + 1)'(sts_i.tap_count - 1'b1);
  assign k_end_max = k_q == TAP_W'(MAX_TAPS - 1);

  // State, tap counter and drain counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      k_q     <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_CLR: begin
          k_q <= k_q + 1'b1;
          if (k_end_max) begin
            k_q     <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          k_q   <= '0;
          cnt_q <= '0;
          if (in_acc_i) begin
            case (kind_e'(kind_i))
              KIND_SAMPLE: state_q <= ST_FADE;
              KIND_COMMIT: state_q <= ST_CMP;
              default:     state_q <= ST_IDLE;
            endcase
          end
        end
        ST_FADE: begin
          if (!sts_i.fading || sts_i.last) begin
            state_q <= ST_HWR;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (sts_i.div_done) begin
            state_q <= ST_HWR;
          end
        end
        ST_HWR: begin
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          k_q <= k_q + 1'b1;
          if (k_end_tc) begin
            state_q <= ST_MDRAIN;
          end
        end
        ST_MDRAIN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 2'd2) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_CMP: begin
          k_q <= k_q + 1'b1;
          if (k_end_tc) begin
            state_q <= ST_CDRAIN;
          end
        end
        ST_CDRAIN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 2'd1) begin
            cnt_q   <= '0;
            k_q     <= '0;
            state_q <= sts_i.diff ? ST_COPY : ST_IDLE;
          end
        end
        ST_COPY: begin
          k_q <= k_q + 1'b1;
          if (k_end_max) begin
            state_q <= ST_PDRAIN;
          end
        end
        ST_PDRAIN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 2'd1) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_MAC;
    cmd_o.k         = k_q;
    case (state_q)
      ST_CLR:  cmd_o.clr = 1'b1;
      ST_IDLE: cmd_o.cmp_clr = 1'b1;
      ST_FADE: begin
        if (sts_i.fading && sts_i.last) begin
          cmd_o.fade_step = 1'b1;
        end else if (sts_i.fading) begin
          cmd_o.div_start = 1'b1;
        end
      end
      ST_DIV:  cmd_o.fade_step = sts_i.div_done;
      ST_HWR: begin
        cmd_o.hist_wr = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      ST_MAC:  cmd_o.rd = 1'b1;
      ST_OUT:  cmd_o.out_load = sts_i.out_free;
      ST_CMP: begin
        cmd_o.rd = 1'b1;
        cmd_o.op = OP_CMP;
      end
      ST_COPY: begin
        cmd_o.rd = 1'b1;
        cmd_o.op = OP_COPY;
      end
      ST_PDRAIN: cmd_o.commit = (cnt_q == 2'd1);
      default: cmd_o.k = k_q;
    endcase
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

>>> hdl/fir_filter_with_coefficient_crossfade_unit.sv
// Top level of the FIR filter with coefficient crossfade.
// Depends on fcf_pkg, fcf_ctrl and fcf_dp.
//
// Usage:
// Input items arrive on a valid/ready channel; kind selects an audio sample,
// a load of one pending coefficient, or a commit of the pending bank.
// Only samples give a result, on the valid/ready output channel.
// A load leaves the block ready for the next item. A sample walks the
// taps through the single shared multiply-accumulate, after a weight
// division while a crossfade runs. A commit compares the pending and
// target banks over the taps and, when they differ, copies all entries.
// After reset the block sweeps all 64 entries clearing the coefficient
// banks with in_ready_o low; configuration writes are taken during the sweep.
// Configuration writes go through cfg_we_i / cfg_index_i / cfg_data_i and
// take effect at once; write them only while the block is idle.
// A finished result waits in an output register; while the receiver stalls,
// the block keeps taking loads and commits, and a further sample stops
// before its result until the register frees.
module fir_filter_with_coefficient_crossfade_unit
  import fcf_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [TAP_W-1:0]              tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [COEF_BITS-1:0]   coefficient_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  fcf_cmd_t cmd;
  fcf_sts_t sts;
  logic     in_acc;

  // Input transaction strobe.
  assign in_acc = in_valid_i && in_ready_o;

  fcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  fcf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_acc_i      (in_acc),
    .kind_i        (kind_i),
    .tap_index_i   (tap_index_i),
    .sample_i      (sample_i),
    .coefficient_i (coefficient_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .filtered_o    (filtered_o)
  );

endmodule

>>> hdl/fcf_chk.sv
// Port-level checker for the FIR filter with coefficient crossfade, and its bind.
// Depends on fcf_pkg and fir_filter_with_coefficient_crossfade_unit.
module fcf_chk
  import fcf_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [1:0]                    kind_i,
  input logic [TAP_W-1:0]              tap_index_i,
  input logic signed [SAMPLE_BITS-1:0] sample_i,
  input logic signed [COEF_BITS-1:0]   coefficient_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] filtered_o,
  input logic                          cfg_we_i,
  input logic [CFG_IDX_W-1:0]          cfg_index_i,
  input logic [CFG_W-1:0]              cfg_data_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(filtered_o))
    else $error("result changed while stalled");

  // A sample transaction occupies the block in the following cycle.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_SAMPLE |=> !in_ready_o)
    else $error("block ready right after a sample");

  // The clearing sweep holds off input right after reset.
  a_reset_sweep: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input taken during clearing sweep");

  // A new result appears only at the end of sample processing.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while idle");

endmodule

bind fir_filter_with_coefficient_crossfade_unit fcf_chk u_fcf_chk (.*);
